>>> src/lkvc_pkg.sv
// shared constants and types for the lru key/value cache
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned OCC_W   = $clog2(ENTRIES + 1);
  localparam int unsigned LIM_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_e;

  // one slot of the recency chain
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } entry_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic              cmp;
    logic              upd;
    logic              hit;
    logic              evict;
    logic [DATA_W-1:0] key;
  } cell_ctrl_t;

endpackage

>>> src/lkvc_cell.sv
// one cell of the recency chain: holds an entry, compares its key, shifts down
`timescale 1ns / 1ps

module lkvc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkvc_pkg::cell_ctrl_t ctrl_i,
  input  lkvc_pkg::entry_t    prev_i,
  input  logic                next_valid_i,
  input  logic                below_i,
  output logic                below_o,
  output lkvc_pkg::entry_t    entry_o,
  output logic                match_o
);
  import lkvc_pkg::*;

  logic              valid_q;
  logic              valid_d;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] key_d;
  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] value_d;
  logic              match_q;
  logic              match_d;
  logic              stop_here;
  logic              shift;

  // stop cell: matched entry on a hit, last valid entry on eviction,
  // first free cell on a plain insert
  always_comb begin
    if (ctrl_i.hit) begin
      stop_here = match_q;
    end else if (ctrl_i.evict) begin
      stop_here = valid_q & ~next_valid_i;
    end else begin
      stop_here = ~valid_q & prev_i.valid;
    end
  end

  assign below_o = below_i | stop_here;
  assign shift   = ctrl_i.upd & below_o;

  always_comb begin
    match_d = match_q;
    if (ctrl_i.cmp) begin
      match_d = valid_q & (key_q == ctrl_i.key);
    end
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (shift) begin
      valid_d = prev_i.valid;
      key_d   = prev_i.key;
      value_d = prev_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;
  assign match_o       = match_q;

endmodule

>>> src/lru_key_value_cache.sv
// top level of the lru key/value cache: request control, occupancy and the cell chain
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement.
// A request (mode_i, lookup_key_i, write_value_i) is taken at a rising edge
// with start high and busy low. mode 0 is a get, mode 1 a put.
// Entries sit in a chain of cells ordered by recency, cell 0 most recent.
// The cycle after acceptance every cell compares its key with the request;
// the next cycle, on a hit or a put, the chain shifts one place from the front
// down to the hit, evicted or free cell, and the touched entry lands in cell 0.
// busy is high for the compare cycle only, so a new request can be taken in
// the shift cycle of the one before; the compare-then-shift pass sets this pace.
// The result (hit_o, read_value_o) shows for exactly one cycle with valid_o
// high, registered at the end of the shift cycle; the receiver cannot stall it.
// read_value_o is the stored value on a get hit, all ones on a get miss and
// zero for a put.
// The capacity register is written over cfg_valid_i / cfg_ready_o, which is
// always ready; write it only while no request is in flight.
// Reset clears all valid marks, the occupancy count and the request state,
// and sets capacity to 16.
module lru_key_value_cache (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             mode_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0] lookup_key_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0] write_value_i,
  output logic                             valid_o,
  output logic                             hit_o,
  output logic signed [lkvc_pkg::DATA_W-1:0] read_value_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lkvc_pkg::CAP_W-1:0]       cfg_data_i
);
  import lkvc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  state_e            state_q;
  logic              mode_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] wval_q;
  logic [CAP_W-1:0]  cap_q;
  logic [OCC_W-1:0]  occ_q;
  logic [OCC_W-1:0]  occ_d;

  logic              accept;
  logic              is_put;
  logic              any_hit;
  logic              evict;
  logic [DATA_W-1:0] hit_value;
  logic [LIM_W-1:0]  cap_ext;
  logic [LIM_W-1:0]  limit;

  cell_ctrl_t        ctrl;
  entry_t            front;
  entry_t            ent [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic [ENTRIES:0]  below;

  assign busy        = (state_q == S_CMP);
  assign accept      = start & ~busy;
  assign cfg_ready_o = 1'b1;
  assign is_put      = (mode_q == MODE_PUT);

  // matched value; keys are unique among valid entries so at most one match
  always_comb begin
    hit_value = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (match[j]) begin
        hit_value = hit_value | ent[j].value;
      end
    end
  end
  assign any_hit = |match;

  // capacity of zero acts as one, above the chain length it saturates
  always_comb begin
    cap_ext = LIM_W'(cap_q);
    if (cap_q == '0) begin
      limit = LIM_W'(1);
    end else if (cap_ext > LIM_W'(ENTRIES)) begin
      limit = LIM_W'(ENTRIES);
    end else begin
      limit = cap_ext;
    end
  end
  assign evict = LIM_W'(occ_q) >= limit;

  assign ctrl.cmp   = (state_q == S_CMP);
  assign ctrl.upd   = (state_q == S_UPD) & (any_hit | is_put);
  assign ctrl.hit   = any_hit;
  assign ctrl.evict = evict;
  assign ctrl.key   = key_q;

  assign front.valid = 1'b1;
  assign front.key   = key_q;
  assign front.value = is_put ? wval_q : hit_value;

  assign below[ENTRIES] = 1'b0;

  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    entry_t prev;
    logic   next_valid;
    if (j == 0) begin : g_first
      assign prev = front;
    end else begin : g_mid
      assign prev = ent[j-1];
    end
    if (j == ENTRIES - 1) begin : g_last
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_valid = ent[j+1].valid;
    end
    lkvc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_i       (prev),
      .next_valid_i (next_valid),
      .below_i      (below[j+1]),
      .below_o      (below[j]),
      .entry_o      (ent[j]),
      .match_o      (match[j])
    );
  end

  // occupancy grows only on a put miss that finds a free cell
  always_comb begin
    occ_d = occ_q;
    if (state_q == S_UPD && is_put && !any_hit && !evict) begin
      occ_d = occ_q + OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      cap_q <= CAP_RESET;
    end else begin
      occ_q <= occ_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_o      <= 1'b0;
      hit_o        <= 1'b0;
      read_value_o <= '0;
      mode_q       <= 1'b0;
      key_q        <= '0;
      wval_q       <= '0;
    end else begin
      valid_o <= 1'b0;
      if (accept) begin
        mode_q <= mode_i;
        key_q  <= lookup_key_i;
        wval_q <= write_value_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          valid_o <= 1'b1;
          hit_o   <= any_hit;
          if (is_put) begin
            read_value_o <= PUT_VALUE;
          end else if (any_hit) begin
            read_value_o <= hit_value;
          end else begin
            read_value_o <= MISS_VALUE;
          end
          state_q <= accept ? S_CMP : S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> verif/tb_top.sv
// testbench for the lru key/value cache: queued stimulus, shadow cache, result checks
`timescale 1ns / 1ps

module tb_top;
  import lkvc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    mode_e             op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] wdata;
    int unsigned       gap;
  } req_t;

  typedef struct {
    logic              hit;
    logic [DATA_W-1:0] rdata;
  } reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                mode_i = 1'b0;
  logic [DATA_W-1:0]   lookup_key_i = '0;
  logic [DATA_W-1:0]   write_value_i = '0;
  logic                valid_o;
  logic                hit_o;
  logic [DATA_W-1:0]   read_value_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CAP_W-1:0]    cfg_data_i = '0;

  req_t        req_q[$];
  reply_t      due_replies[$];
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_cnt = 0;
  logic        took = 1'b0;

  // shadow copy of the cache contents
  logic [DATA_W-1:0] key_mem [ENTRIES];
  logic [DATA_W-1:0] val_mem [ENTRIES];
  logic              used    [ENTRIES];
  int unsigned       rank    [ENTRIES];
  int unsigned       fill;
  logic [CAP_W-1:0]  cap_reg;

  lru_key_value_cache i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .lookup_key_i  (lookup_key_i),
    .write_value_i (write_value_i),
    .valid_o       (valid_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void cache_clear();
    for (int i = 0; i < ENTRIES; i++) begin
      used[i] = 1'b0;
      rank[i] = 0;
    end
    fill = 0;
    cap_reg = CAP_RESET;
  endfunction

  // move a slot to the front; entries that were more recent age by one
  function automatic void promote(int slot, int unsigned old);
    for (int i = 0; i < ENTRIES; i++)
      if (used[i] && i != slot && rank[i] < old) rank[i]++;
    rank[slot] = 0;
  endfunction

  function automatic reply_t cache_access(mode_e op, logic [DATA_W-1:0] k,
                                          logic [DATA_W-1:0] v);
    reply_t      r;
    int          found;
    int          victim;
    int          free_slot;
    int unsigned lim;
    int unsigned oldest;
    found = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && used[i] && key_mem[i] == k) found = i;
    r.hit = (found >= 0);
    if (op == MODE_GET) begin
      if (found >= 0) begin
        r.rdata = val_mem[found];
        promote(found, rank[found]);
      end else begin
        r.rdata = MISS_VALUE;
      end
      return r;
    end
    r.rdata = PUT_VALUE;
    // zero counts as one, anything above the slot count saturates
    lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
    if (found >= 0) begin
      val_mem[found] = v;
      promote(found, rank[found]);
    end else if (fill >= lim) begin
      victim = -1;
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (used[i] && (victim < 0 || rank[i] > oldest)) begin
          victim = i;
          oldest = rank[i];
        end
      if (victim >= 0) begin
        key_mem[victim] = k;
        val_mem[victim] = v;
        promote(victim, oldest);
      end
    end else begin
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (free_slot < 0 && !used[i]) free_slot = i;
      for (int i = 0; i < ENTRIES; i++)
        if (used[i]) rank[i]++;
      used[free_slot] = 1'b1;
      key_mem[free_slot] = k;
      val_mem[free_slot] = v;
      rank[free_slot] = 0;
      fill++;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  // driver: one transaction per request, a random gap before each unless queued calm
  always @(negedge clk_i) begin : drive_req
    req_t cur;
    if (!rst_ni) begin
      start <= 1'b0;
      gap_cnt <= 0;
    end else if (start && !took) begin
      // hold until accepted
    end else if (req_q.size() == 0) begin
      start <= 1'b0;
    end else if (gap_cnt < req_q[0].gap) begin
      start <= 1'b0;
      gap_cnt <= gap_cnt + 1;
    end else begin
      cur = req_q.pop_front();
      start <= 1'b1;
      mode_i <= cur.op;
      lookup_key_i <= cur.key;
      write_value_i <= cur.wdata;
      gap_cnt <= 0;
    end
  end

  // monitor: check results, track config writes, predict accepted requests
  always @(posedge clk_i) begin : watch_port
    reply_t want;
    if (!rst_ni) begin
      cache_clear();
      took <= 1'b0;
    end else begin
      if (valid_o) begin
        if (due_replies.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = due_replies.pop_front();
          if (hit_o !== want.hit)
            report_mismatch($sformatf("hit %b, expected %b", hit_o, want.hit));
          if (read_value_o !== want.rdata)
            report_mismatch($sformatf("read value %h, expected %h",
                                      read_value_o, want.rdata));
        end
      end
      if (cfg_valid_i && cfg_ready_o) cap_reg = cfg_data_i;
      took <= start && !busy;
      if (start && !busy) begin
        due_replies.push_back(cache_access(mode_e'(mode_i), lookup_key_i, write_value_i));
        n_taken <= n_taken + 1;
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic queue_req(input mode_e op, input logic [DATA_W-1:0] k,
                           input logic [DATA_W-1:0] v, input bit calm);
    req_t r;
    r.op = op;
    r.key = k;
    r.wdata = v;
    r.gap = calm ? 0 : $urandom_range(0, 8);
    req_q.push_back(r);
    n_queued++;
  endtask

  // wait until every queued request has been answered
  task automatic drain();
    @(negedge clk_i);
    while (n_taken != n_queued || due_replies.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [CAP_W-1:0] c, input int unsigned n);
    logic [DATA_W-1:0] pool[$];
    logic [DATA_W-1:0] k;
    logic [DATA_W-1:0] v;
    int unsigned       lim;
    int unsigned       psize;
    bit                calm;
    write_capacity(c);
    lim = (c == 0) ? 1 : ((c > ENTRIES) ? ENTRIES : c);
    psize = lim + $urandom_range(1, 4);
    for (int i = 0; i < psize; i++) pool.push_back($urandom());
    pool[0] = (c[0]) ? 32'h8000_0000 : 32'h7fff_ffff;
    calm = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      k = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, psize - 1)];
      case ($urandom_range(0, 15))
        0:       v = '0;
        1:       v = '1;
        2:       v = 32'h8000_0000;
        3:       v = 32'h7fff_ffff;
        default: v = $urandom();
      endcase
      queue_req($urandom_range(0, 1) ? MODE_PUT : MODE_GET, k, v, calm);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps[11];
    caps = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd8, 5'd12, 5'd15, 5'd16, 5'd17, 5'd31};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty cache, extreme keys and values, update of an existing key
    queue_req(MODE_GET, 32'h0000_0000, 32'h5555_5555, 1'b0);
    queue_req(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    queue_req(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    queue_req(MODE_PUT, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    queue_req(MODE_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_req(MODE_GET, 32'h8000_0000, 32'h0, 1'b1);
    queue_req(MODE_GET, 32'h7fff_ffff, 32'h0, 1'b0);
    queue_req(MODE_GET, 32'hffff_ffff, 32'h0, 1'b1);
    queue_req(MODE_GET, 32'h0000_0000, 32'h0, 1'b0);
    queue_req(MODE_PUT, 32'h0000_0000, 32'h0000_1234, 1'b0);
    queue_req(MODE_GET, 32'h0000_0000, 32'h0, 1'b1);
    queue_req(MODE_GET, 32'h0000_0001, 32'h0, 1'b0);

    // capacity lowered below occupancy: misses replace the oldest entry
    write_capacity(5'd2);
    queue_req(MODE_PUT, 32'h0000_000a, 32'h0000_0001, 1'b0);
    queue_req(MODE_GET, 32'h8000_0000, 32'h0, 1'b1);
    queue_req(MODE_GET, 32'h0000_000a, 32'h0, 1'b0);
    queue_req(MODE_PUT, 32'h0000_000b, 32'h0000_0002, 1'b1);
    queue_req(MODE_GET, 32'h7fff_ffff, 32'h0, 1'b0);
    queue_req(MODE_GET, 32'hffff_ffff, 32'h0, 1'b0);

    // zero capacity behaves as one
    write_capacity(5'd0);
    queue_req(MODE_PUT, 32'h0000_000c, 32'h0000_0003, 1'b0);
    queue_req(MODE_GET, 32'h0000_000c, 32'h0, 1'b1);
    queue_req(MODE_GET, 32'h0000_000b, 32'h0, 1'b0);

    foreach (caps[i]) random_phase(caps[i], 150);

    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lkvc_pkg.sv
src/lkvc_cell.sv
src/lru_key_value_cache.sv
verif/tb_top.sv
